FILE: rtl/lcbt_pkg.sv
// lcbt_pkg: types and codes shared by the coherence block tracker
// no dependencies
package lcbt_pkg;

   localparam int IDX_W = 5;
   localparam int SLOTS = 1 << IDX_W;
   localparam int CNT_W = IDX_W + 1;

   typedef enum logic [3:0] {
      FN_READ_FAULT  = 4'd0,
      FN_WRITE_FAULT = 4'd1,
      FN_ACQUIRE     = 4'd2,
      FN_RELEASE     = 4'd3,
      FN_RELEASE_ALL = 4'd4,
      FN_MAP         = 4'd5,
      FN_UNMAP       = 4'd6,
      FN_TO_HOST     = 4'd7,
      FN_DELETE      = 4'd8
   } func_type;

   typedef enum logic [1:0] {
      ST_INV   = 2'd0,
      ST_RO    = 2'd1,
      ST_DIRTY = 2'd2,
      ST_HOST  = 2'd3
   } coh_state_type;

   typedef enum logic [1:0] {
      PR_NONE = 2'd0,
      PR_RO   = 2'd1,
      PR_RW   = 2'd2,
      PR_KEEP = 2'd3
   } prot_type;

   localparam logic CSR_EAGER  = 1'b0;
   localparam logic CSR_THRESH = 1'b1;

   // last field in the low bits
   typedef struct packed {
      logic                  warning;
      prot_type              protection;
      logic                  flush_to_device;
      logic                  fetch_to_host;
      coh_state_type         new_state;
      logic [IDX_W-1:0]      out_block;
   } item_type;

   typedef struct packed {
      logic             append;
      logic             drop;
      logic [IDX_W-1:0] pos;
      logic [IDX_W-1:0] blk;
   } list_cmd_type;

endpackage

FILE: rtl/lazy_coherence_block_tracker_unit.sv
// lazy_coherence_block_tracker_unit: top level, event sequencer and per-block tables
// depends on lcbt_pkg and lcbt_list
//
// usage:
//   req_ channel: one beat per coherence event (func, block index, acquire write flag)
//   rsp_ channel: one or more beats per event, rsp_tlast on the final beat of an event
//   csr_ port: reg 0 eager mode, reg 1 roll threshold, write only while idle
// timing:
//   the sequencer handles one event at a time; req_tready is high only when idle
//   simple events: S_EXEC, then S_PRIM loads the result beat into the output register
//   list removal or insertion walks the dirty list in S_SEARCH, one entry a cycle, then
//   insertion passes S_ADD and both give the result beat from S_PRIM
//   each flushed or evicted block gives a result beat, one a cycle while the output is free
//   events with unknown func or block index >= NUM_BLOCKS give no beat
// reset:
//   all blocks host-only, fault counts zero, list empty, limit one, eager off, threshold 4
// stalls:
//   a result beat sits in the output register until taken; the sequencer waits on it
module lazy_coherence_block_tracker_unit #(
   parameter int NUM_BLOCKS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // func[3:0], block_index[8:4], acquire_write[9]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_block[4:0], new_state[6:5], fetch_to_host[7],
                                    // flush_to_device[8], protection[10:9], warning[11]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int IW = lcbt_pkg::IDX_W;
   localparam int CW = lcbt_pkg::CNT_W;
   localparam logic [CW-1:0] NB = CW'(NUM_BLOCKS);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_EXEC   = 6'b000010,
      S_SEARCH = 6'b000100,
      S_ADD    = 6'b001000,
      S_PRIM   = 6'b010000,
      S_FLUSH  = 6'b100000
   } fsm_type;

   typedef enum logic [1:0] {
      M_SIMPLE = 2'd0,
      M_REMOVE = 2'd1,
      M_ADD    = 2'd2,
      M_RALL   = 2'd3
   } mode_type;

   fsm_type  state_ff, state_in;
   mode_type mode_ff, mode_in;

   lcbt_pkg::func_type   func_ff;
   logic [IW-1:0]        blk_ff;
   logic                 wr_ff;
   logic [CW-1:0]        ptr_ff, ptr_in;
   lcbt_pkg::item_type   prim_ff, prim_in;

   lcbt_pkg::coh_state_type blk_state_ff [lcbt_pkg::SLOTS];
   logic [7:0]              fault_ff     [lcbt_pkg::SLOTS];

   logic       eager_ff;
   logic [7:0] thresh_ff;
   logic [CW-1:0] limit_ff, limit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   lcbt_pkg::item_type rsp_item_ff, rsp_item_in;
   logic               rsp_last_ff, rsp_last_in;

   // table write port
   logic                    st_we;
   logic [IW-1:0]           st_addr;
   lcbt_pkg::coh_state_type st_wdata;
   logic                    fc_we;
   logic [7:0]              fc_wdata;

   lcbt_pkg::list_cmd_type list_cmd;
   logic [IW-1:0] rd_blk, head_blk;
   logic [CW-1:0] count;

   lcbt_pkg::coh_state_type cur_st, head_st;
   logic [7:0]              cur_fc;
   logic                    out_free;
   logic                    evict_more;

   lcbt_list u_list (
      .clock    (clock),
      .reset    (reset),
      .cmd      (list_cmd),
      .rd_pos   (ptr_ff[IW-1:0]),
      .rd_blk   (rd_blk),
      .head_blk (head_blk),
      .count    (count)
   );

   assign cur_st     = blk_state_ff[blk_ff];
   assign cur_fc     = fault_ff[blk_ff];
   assign head_st    = blk_state_ff[head_blk];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign evict_more = eager_ff && (count > limit_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_item_ff};
   assign rsp_tlast  = rsp_last_ff;

   function automatic lcbt_pkg::item_type mk_item(
      input logic [IW-1:0] b, input lcbt_pkg::coh_state_type s, input logic fe,
      input logic fl, input lcbt_pkg::prot_type p, input logic w);
      lcbt_pkg::item_type it;
      it.out_block       = b;
      it.new_state       = s;
      it.fetch_to_host   = fe;
      it.flush_to_device = fl;
      it.protection      = p;
      it.warning         = w;
      return it;
   endfunction

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      ptr_in       = ptr_ff;
      prim_in      = prim_ff;
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_item_in  = rsp_item_ff;
      rsp_last_in  = rsp_last_ff;
      st_we        = 1'b0;
      st_addr      = blk_ff;
      st_wdata     = lcbt_pkg::ST_HOST;
      fc_we        = 1'b0;
      fc_wdata     = cur_fc;
      list_cmd     = '0;
      list_cmd.blk = blk_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tdata[3:0] <= lcbt_pkg::FN_DELETE &&
                {1'b0, req_tdata[8:4]} < NB) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            ptr_in   = '0;
            mode_in  = M_SIMPLE;
            state_in = S_PRIM;
            prim_in  = mk_item(blk_ff, cur_st, 1'b0, 1'b0, lcbt_pkg::PR_KEEP, 1'b0);
            unique case (func_ff)
               lcbt_pkg::FN_READ_FAULT: begin
                  if (cur_st == lcbt_pkg::ST_HOST) begin
                     prim_in = mk_item(blk_ff, cur_st, 1'b0, 1'b0, lcbt_pkg::PR_RW, 1'b1);
                  end else if (cur_st == lcbt_pkg::ST_INV) begin
                     st_we    = 1'b1;
                     st_wdata = lcbt_pkg::ST_RO;
                     prim_in  = mk_item(blk_ff, lcbt_pkg::ST_RO, 1'b1, 1'b0,
                                        lcbt_pkg::PR_RO, 1'b0);
                  end else begin
                     prim_in = mk_item(blk_ff, cur_st, 1'b0, 1'b0, lcbt_pkg::PR_RO, 1'b0);
                  end
               end
               lcbt_pkg::FN_WRITE_FAULT: begin
                  fc_we    = (cur_fc != 8'hFF);
                  fc_wdata = cur_fc + 8'd1;
                  prim_in  = mk_item(blk_ff, lcbt_pkg::ST_DIRTY,
                                     cur_st == lcbt_pkg::ST_INV, 1'b0, lcbt_pkg::PR_RW,
                                     cur_st == lcbt_pkg::ST_HOST);
                  if (cur_st != lcbt_pkg::ST_DIRTY) begin
                     st_we    = 1'b1;
                     st_wdata = lcbt_pkg::ST_DIRTY;
                     mode_in  = M_ADD;
                     state_in = S_SEARCH;
                  end
               end
               lcbt_pkg::FN_ACQUIRE: begin
                  if ((cur_st == lcbt_pkg::ST_INV || cur_st == lcbt_pkg::ST_RO) && wr_ff) begin
                     st_we    = 1'b1;
                     st_wdata = lcbt_pkg::ST_INV;
                     prim_in  = mk_item(blk_ff, lcbt_pkg::ST_INV, 1'b0, 1'b0,
                                        lcbt_pkg::PR_NONE, 1'b0);
                  end else begin
                     prim_in = mk_item(blk_ff, cur_st, 1'b0, 1'b0, lcbt_pkg::PR_KEEP,
                                       cur_st == lcbt_pkg::ST_DIRTY);
                  end
               end
               lcbt_pkg::FN_RELEASE: begin
                  if (cur_st == lcbt_pkg::ST_DIRTY) begin
                     st_we    = 1'b1;
                     st_wdata = lcbt_pkg::ST_RO;
                     prim_in  = mk_item(blk_ff, lcbt_pkg::ST_RO, 1'b0, 1'b1,
                                        lcbt_pkg::PR_RO, 1'b0);
                     mode_in  = M_REMOVE;
                     state_in = S_SEARCH;
                  end
               end
               lcbt_pkg::FN_RELEASE_ALL: begin
                  if (eager_ff && count < limit_ff && limit_ff > CW'(1)) begin
                     limit_in = limit_ff >> 1;
                  end
                  if (count != '0) begin
                     mode_in  = M_RALL;
                     state_in = S_FLUSH;
                  end
               end
               lcbt_pkg::FN_MAP: begin
                  st_we    = 1'b1;
                  st_wdata = lcbt_pkg::ST_DIRTY;
                  prim_in  = mk_item(blk_ff, lcbt_pkg::ST_DIRTY, 1'b0, 1'b0,
                                     lcbt_pkg::PR_KEEP, 1'b0);
                  mode_in  = M_ADD;
                  state_in = S_SEARCH;
               end
               lcbt_pkg::FN_UNMAP: begin
                  st_we    = 1'b1;
                  st_wdata = lcbt_pkg::ST_HOST;
                  prim_in  = mk_item(blk_ff, lcbt_pkg::ST_HOST, cur_st == lcbt_pkg::ST_INV,
                                     1'b0, lcbt_pkg::PR_RW, 1'b0);
                  mode_in  = M_REMOVE;
                  state_in = S_SEARCH;
               end
               lcbt_pkg::FN_TO_HOST: begin
                  if (cur_st == lcbt_pkg::ST_INV) begin
                     st_we    = 1'b1;
                     st_wdata = lcbt_pkg::ST_RO;
                     prim_in  = mk_item(blk_ff, lcbt_pkg::ST_RO, 1'b1, 1'b0,
                                        lcbt_pkg::PR_RO, 1'b0);
                  end
               end
               lcbt_pkg::FN_DELETE: begin
                  mode_in  = M_REMOVE;
                  state_in = S_SEARCH;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SEARCH: begin
            // one compare per cycle along the list
            if (ptr_ff >= count) begin
               if (mode_ff == M_ADD) begin
                  list_cmd.append = 1'b1;
                  state_in        = S_ADD;
               end else begin
                  state_in = S_PRIM;
               end
            end else if (rd_blk == blk_ff) begin
               if (mode_ff == M_ADD) begin
                  state_in = S_ADD;
               end else begin
                  list_cmd.drop = 1'b1;
                  list_cmd.pos  = ptr_ff[IW-1:0];
                  state_in      = S_PRIM;
               end
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_ADD: begin
            if (eager_ff && cur_fc >= thresh_ff) begin
               fc_we    = 1'b1;
               fc_wdata = 8'd0;
               if (limit_ff < NB) begin
                  limit_in = limit_ff + 1'b1;
               end
            end
            state_in = S_PRIM;
         end
         S_PRIM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = prim_ff;
               if (mode_ff == M_ADD && evict_more) begin
                  rsp_last_in = 1'b0;
                  state_in    = S_FLUSH;
               end else begin
                  rsp_last_in = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               list_cmd.drop = 1'b1;
               list_cmd.pos  = '0;
               rsp_valid_in  = 1'b1;
               st_addr       = head_blk;
               if (head_st == lcbt_pkg::ST_DIRTY) begin
                  st_we       = 1'b1;
                  st_wdata    = lcbt_pkg::ST_RO;
                  rsp_item_in = mk_item(head_blk, lcbt_pkg::ST_RO, 1'b0, 1'b1,
                                        lcbt_pkg::PR_RO, 1'b0);
               end else begin
                  rsp_item_in = mk_item(head_blk, head_st, 1'b0, 1'b0,
                                        lcbt_pkg::PR_KEEP, 1'b0);
               end
               if (mode_ff == M_RALL) begin
                  rsp_last_in = (count == CW'(1));
               end else begin
                  rsp_last_in = ((count - CW'(1)) <= limit_ff);
               end
               if (rsp_last_in) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_SIMPLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= CW'(1);
         eager_ff     <= 1'b0;
         thresh_ff    <= 8'd4;
         for (int i = 0; i < lcbt_pkg::SLOTS; i++) begin
            blk_state_ff[i] <= lcbt_pkg::ST_HOST;
            fault_ff[i]     <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
         if (csr_we) begin
            unique case (csr_index)
               lcbt_pkg::CSR_EAGER:  eager_ff  <= csr_wdata[0];
               lcbt_pkg::CSR_THRESH: thresh_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (st_we) begin
            blk_state_ff[st_addr] <= st_wdata;
         end
         if (fc_we) begin
            fault_ff[blk_ff] <= fc_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         func_ff <= lcbt_pkg::func_type'(req_tdata[3:0]);
         blk_ff  <= req_tdata[8:4];
         wr_ff   <= req_tdata[9];
      end
      ptr_ff      <= ptr_in;
      prim_ff     <= prim_in;
      rsp_item_ff <= rsp_item_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

FILE: rtl/lcbt_list.sv
// lcbt_list: ordered dirty list, oldest entry at slot zero
// depends on lcbt_pkg
module lcbt_list (
   input  logic                       clock,
   input  logic                       reset,
   input  lcbt_pkg::list_cmd_type     cmd,
   input  logic [lcbt_pkg::IDX_W-1:0] rd_pos,
   output logic [lcbt_pkg::IDX_W-1:0] rd_blk,
   output logic [lcbt_pkg::IDX_W-1:0] head_blk,
   output logic [lcbt_pkg::CNT_W-1:0] count
);

   logic [lcbt_pkg::IDX_W-1:0] entry_ff [lcbt_pkg::SLOTS];
   logic [lcbt_pkg::CNT_W-1:0] count_ff;
   logic [lcbt_pkg::CNT_W-1:0] count_in;

   assign rd_blk   = entry_ff[rd_pos];
   assign head_blk = entry_ff[0];
   assign count    = count_ff;

   always_comb begin
      count_in = count_ff;
      if (cmd.drop && count_ff != '0) begin
         count_in = count_ff - 1'b1;
      end else if (cmd.append && count_ff < lcbt_pkg::CNT_W'(lcbt_pkg::SLOTS)) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // entries need no reset: only the first count_ff are read
   always_ff @(posedge clock) begin
      if (cmd.drop) begin
         for (int i = 0; i < lcbt_pkg::SLOTS - 1; i++) begin
            if (lcbt_pkg::IDX_W'(i) >= cmd.pos) begin
               entry_ff[i] <= entry_ff[i+1];
            end
         end
      end else if (cmd.append && count_ff < lcbt_pkg::CNT_W'(lcbt_pkg::SLOTS)) begin
         entry_ff[count_ff[lcbt_pkg::IDX_W-1:0]] <= cmd.blk;
      end
   end

endmodule

FILE: tb/sv/tb_lazy_coherence_block_tracker_unit.sv
// tb_lazy_coherence_block_tracker_unit: self-checking bench for the coherence block tracker
// depends on lcbt_pkg and lazy_coherence_block_tracker_unit; an internal state predictor
// checks every rsp_ beat, with random idles on both channels
module tb_lazy_coherence_block_tracker_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import lcbt_pkg::*;

   localparam int NBLK = 32;

   typedef struct {
      logic [4:0]    blk;
      coh_state_type st;
      logic          fetch;
      logic          flush;
      prot_type      prot;
      logic          warn;
      logic          last;
   } beat_type;

   typedef struct {
      func_type   fn;
      logic [3:0] raw_fn;   // used when use_raw is set, for undefined codes
      logic       use_raw;
      logic [4:0] blk;
      logic       wr;
      logic       typed;    // expected beat given in the row
      beat_type   beat;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic        csr_index;
   logic [7:0]  csr_wdata;

   lazy_coherence_block_tracker_unit #(.NUM_BLOCKS(NBLK)) DUT (.*);

   // tracker state as predicted
   coh_state_type blk_state [NBLK];
   logic [7:0]    wfault_cnt [NBLK];
   logic [4:0]    dirty_blocks [$];
   int            dirty_cap;
   logic          eager_on;
   logic [7:0]    roll_thresh;

   beat_type expected_beats [$];
   int       errors;
   int       quiet;
   int       pred_n;   // beats predicted for the latest event

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void emit_beat(logic [4:0] b, coh_state_type s, logic fe, logic fl,
                                     prot_type p, logic w);
      beat_type t;
      t = '{blk: b, st: s, fetch: fe, flush: fl, prot: p, warn: w, last: 1'b0};
      expected_beats.push_back(t);
   endfunction

   function automatic int dirty_pos(logic [4:0] b);
      foreach (dirty_blocks[i])
         if (dirty_blocks[i] == b) return i;
      return -1;
   endfunction

   function automatic void unlist(logic [4:0] b);
      int p;
      p = dirty_pos(b);
      if (p >= 0) dirty_blocks.delete(p);
   endfunction

   function automatic void flush_oldest();
      logic [4:0] b;
      b = dirty_blocks.pop_front();
      if (blk_state[b] == ST_DIRTY) begin
         blk_state[b] = ST_RO;
         emit_beat(b, ST_RO, 1'b0, 1'b1, PR_RO, 1'b0);
      end else begin
         emit_beat(b, blk_state[b], 1'b0, 1'b0, PR_KEEP, 1'b0);
      end
   endfunction

   function automatic void mark_dirty(logic [4:0] b);
      if (dirty_pos(b) < 0 && dirty_blocks.size() < NBLK) dirty_blocks.push_back(b);
      if (!eager_on) return;
      if (wfault_cnt[b] >= roll_thresh) begin
         wfault_cnt[b] = 8'd0;
         if (dirty_cap < NBLK) dirty_cap++;
      end
      // evict oldest until the list fits
      while (dirty_blocks.size() > dirty_cap) flush_oldest();
   endfunction

   function automatic void predict_event(logic [3:0] fn, logic [4:0] b, logic wr);
      coh_state_type s;
      int            n0;
      pred_n = 0;
      n0 = expected_beats.size();
      if (fn > FN_DELETE) return;
      s = blk_state[b];
      case (fn)
         FN_READ_FAULT: begin
            if (s == ST_HOST) emit_beat(b, s, 1'b0, 1'b0, PR_RW, 1'b1);
            else if (s == ST_INV) begin
               blk_state[b] = ST_RO;
               emit_beat(b, ST_RO, 1'b1, 1'b0, PR_RO, 1'b0);
            end else emit_beat(b, s, 1'b0, 1'b0, PR_RO, 1'b0);
         end
         FN_WRITE_FAULT: begin
            if (wfault_cnt[b] != 8'd255) wfault_cnt[b]++;
            if (s == ST_DIRTY) emit_beat(b, ST_DIRTY, 1'b0, 1'b0, PR_RW, 1'b0);
            else begin
               blk_state[b] = ST_DIRTY;
               emit_beat(b, ST_DIRTY, s == ST_INV, 1'b0, PR_RW, s == ST_HOST);
               mark_dirty(b);
            end
         end
         FN_ACQUIRE: begin
            if ((s == ST_INV || s == ST_RO) && wr) begin
               blk_state[b] = ST_INV;
               emit_beat(b, ST_INV, 1'b0, 1'b0, PR_NONE, 1'b0);
            end else emit_beat(b, s, 1'b0, 1'b0, PR_KEEP, s == ST_DIRTY);
         end
         FN_RELEASE: begin
            if (s == ST_DIRTY) begin
               blk_state[b] = ST_RO;
               unlist(b);
               emit_beat(b, ST_RO, 1'b0, 1'b1, PR_RO, 1'b0);
            end else emit_beat(b, s, 1'b0, 1'b0, PR_KEEP, 1'b0);
         end
         FN_RELEASE_ALL: begin
            if (eager_on && dirty_blocks.size() < dirty_cap && dirty_cap > 1)
               dirty_cap = dirty_cap / 2;
            if (dirty_blocks.size() == 0) emit_beat(b, s, 1'b0, 1'b0, PR_KEEP, 1'b0);
            while (dirty_blocks.size() > 0) flush_oldest();
         end
         FN_MAP: begin
            blk_state[b] = ST_DIRTY;
            emit_beat(b, ST_DIRTY, 1'b0, 1'b0, PR_KEEP, 1'b0);
            mark_dirty(b);
         end
         FN_UNMAP: begin
            blk_state[b] = ST_HOST;
            unlist(b);
            emit_beat(b, ST_HOST, s == ST_INV, 1'b0, PR_RW, 1'b0);
         end
         FN_TO_HOST: begin
            if (s == ST_INV) begin
               blk_state[b] = ST_RO;
               emit_beat(b, ST_RO, 1'b1, 1'b0, PR_RO, 1'b0);
            end else emit_beat(b, s, 1'b0, 1'b0, PR_KEEP, 1'b0);
         end
         default: begin
            unlist(b);
            emit_beat(b, s, 1'b0, 1'b0, PR_KEEP, 1'b0);
         end
      endcase
      pred_n = expected_beats.size() - n0;
      if (expected_beats.size() > n0) expected_beats[expected_beats.size()-1].last = 1'b1;
   endfunction

   task automatic write_reg(logic idx, logic [7:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_EAGER) eager_on = val[0];
      else roll_thresh = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // next beat goes out at the edge after the gap; valid stays high across back-to-back beats
   task automatic send_event(logic [3:0] fn, logic [4:0] b, logic wr, output logic ok);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, wr, b, fn};
      do @(posedge clock); while (!req_tready);
      predict_event(fn, b, wr);
      ok = 1'b1;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_beats.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      logic [3:0] fn;
      logic [4:0] b;
      logic       ok;
      int         r;
      for (int i = 0; i < count; i++) begin
         if (i % 12 == 0) quiet = ($urandom_range(0, 2) == 0);
         r = $urandom_range(0, 99);
         if (r < 6) fn = 4'($urandom_range(9, 15));
         else if (r < 30) fn = FN_WRITE_FAULT;
         else if (r < 42) fn = FN_MAP;
         else if (r < 52) fn = FN_RELEASE_ALL;
         else fn = 4'($urandom_range(0, 8));
         b = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 5));
         send_event(fn, b, 1'($urandom), ok);
      end
      quiet = 0;
   endtask

   // result side: random stall before each beat
   initial begin
      int stall;
      beat_type e;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (expected_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, actual %h last %b", $realtime, rsp_tdata, rsp_tlast);
         end else begin
            e = expected_beats.pop_front();
            if (rsp_tdata[4:0] !== e.blk || rsp_tdata[6:5] !== e.st ||
                rsp_tdata[7] !== e.fetch || rsp_tdata[8] !== e.flush ||
                rsp_tdata[10:9] !== e.prot || rsp_tdata[11] !== e.warn ||
                rsp_tlast !== e.last) begin
               errors++;
               $display("%0t: mismatch, expected blk %0d st %0d fetch %b flush %b prot %0d warn %b last %b",
                        $realtime, e.blk, e.st, e.fetch, e.flush, e.prot, e.warn, e.last);
               $display("%0t:           actual blk %0d st %0d fetch %b flush %b prot %0d warn %b last %b",
                        $realtime, rsp_tdata[4:0], rsp_tdata[6:5], rsp_tdata[7], rsp_tdata[8],
                        rsp_tdata[10:9], rsp_tdata[11], rsp_tlast);
            end
         end
      end
   end

   initial begin
      row_type  rows [$];
      beat_type none;
      logic     ok;

      none = '{blk: 5'd0, st: ST_INV, fetch: 1'b0, flush: 1'b0, prot: PR_NONE, warn: 1'b0,
               last: 1'b0};
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 16'd0;
      csr_we     = 1'b0;
      csr_index  = CSR_EAGER;
      csr_wdata  = 8'd0;
      errors     = 0;
      quiet      = 0;
      pred_n     = 0;
      for (int i = 0; i < NBLK; i++) begin
         blk_state[i]  = ST_HOST;
         wfault_cnt[i] = 8'd0;
      end
      dirty_cap   = 1;
      eager_on    = 1'b0;
      roll_thresh = 8'd4;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_reg(CSR_EAGER, 8'd0);
      write_reg(CSR_THRESH, 8'd4);

      rows = '{
         '{FN_READ_FAULT, 4'd0, 1'b0, 5'd0, 1'b0, 1'b1,
           '{5'd0, ST_HOST, 1'b0, 1'b0, PR_RW, 1'b1, 1'b1}},
         '{FN_WRITE_FAULT, 4'd0, 1'b0, 5'd0, 1'b0, 1'b1,
           '{5'd0, ST_DIRTY, 1'b0, 1'b0, PR_RW, 1'b1, 1'b1}},
         '{FN_ACQUIRE, 4'd0, 1'b0, 5'd0, 1'b1, 1'b1,
           '{5'd0, ST_DIRTY, 1'b0, 1'b0, PR_KEEP, 1'b1, 1'b1}},
         '{FN_RELEASE, 4'd0, 1'b0, 5'd0, 1'b0, 1'b1,
           '{5'd0, ST_RO, 1'b0, 1'b1, PR_RO, 1'b0, 1'b1}},
         '{FN_ACQUIRE, 4'd0, 1'b0, 5'd0, 1'b1, 1'b1,
           '{5'd0, ST_INV, 1'b0, 1'b0, PR_NONE, 1'b0, 1'b1}},
         '{FN_READ_FAULT, 4'd0, 1'b0, 5'd0, 1'b0, 1'b1,
           '{5'd0, ST_RO, 1'b1, 1'b0, PR_RO, 1'b0, 1'b1}},
         '{FN_ACQUIRE, 4'd0, 1'b0, 5'd31, 1'b0, 1'b1,
           '{5'd31, ST_HOST, 1'b0, 1'b0, PR_KEEP, 1'b0, 1'b1}},
         '{FN_TO_HOST, 4'd0, 1'b0, 5'd31, 1'b0, 1'b1,
           '{5'd31, ST_HOST, 1'b0, 1'b0, PR_KEEP, 1'b0, 1'b1}},
         '{FN_UNMAP, 4'd0, 1'b0, 5'd31, 1'b0, 1'b1,
           '{5'd31, ST_HOST, 1'b0, 1'b0, PR_RW, 1'b0, 1'b1}},
         '{FN_MAP, 4'd0, 1'b0, 5'd31, 1'b0, 1'b1,
           '{5'd31, ST_DIRTY, 1'b0, 1'b0, PR_KEEP, 1'b0, 1'b1}},
         '{FN_WRITE_FAULT, 4'd0, 1'b0, 5'd5, 1'b0, 1'b0, none},
         '{FN_READ_FAULT, 4'd0, 1'b0, 5'd5, 1'b0, 1'b0, none},
         '{FN_DELETE, 4'd0, 1'b0, 5'd31, 1'b0, 1'b0, none},
         '{FN_RELEASE_ALL, 4'd0, 1'b0, 5'd0, 1'b0, 1'b0, none},
         '{FN_RELEASE_ALL, 4'd0, 1'b0, 5'd3, 1'b1, 1'b1,
           '{5'd3, ST_HOST, 1'b0, 1'b0, PR_KEEP, 1'b0, 1'b1}},
         '{FN_READ_FAULT, 4'd9, 1'b1, 5'd1, 1'b0, 1'b0, none},
         '{FN_READ_FAULT, 4'd15, 1'b1, 5'd31, 1'b1, 1'b0, none},
         '{FN_ACQUIRE, 4'd0, 1'b0, 5'd0, 1'b1, 1'b0, none},
         '{FN_TO_HOST, 4'd0, 1'b0, 5'd0, 1'b0, 1'b0, none},
         '{FN_ACQUIRE, 4'd0, 1'b0, 5'd0, 1'b1, 1'b0, none},
         '{FN_UNMAP, 4'd0, 1'b0, 5'd0, 1'b0, 1'b0, none},
         '{FN_WRITE_FAULT, 4'd0, 1'b0, 5'd2, 1'b0, 1'b0, none},
         '{FN_MAP, 4'd0, 1'b0, 5'd2, 1'b0, 1'b0, none},
         '{FN_MAP, 4'd0, 1'b0, 5'd7, 1'b0, 1'b0, none},
         '{FN_RELEASE_ALL, 4'd0, 1'b0, 5'd26, 1'b0, 1'b0, none}
      };

      foreach (rows[i]) begin
         send_event(rows[i].use_raw ? rows[i].raw_fn : 4'(rows[i].fn), rows[i].blk,
                    rows[i].wr, ok);
         if (rows[i].typed) begin
            repeat (pred_n) void'(expected_beats.pop_back());
            expected_beats.push_back(rows[i].beat);
         end
      end
      drain();

      write_reg(CSR_EAGER, 8'd1);
      write_reg(CSR_THRESH, 8'd1);
      random_phase(25);
      drain();

      write_reg(CSR_THRESH, 8'd255);
      random_phase(15);
      drain();

      write_reg(CSR_EAGER, 8'd0);
      write_reg(CSR_THRESH, 8'($urandom_range(1, 255)));
      random_phase(15);
      drain();

      write_reg(CSR_EAGER, 8'd1);
      write_reg(CSR_THRESH, 8'($urandom_range(2, 6)));
      random_phase(20);

      req_tvalid <= 1'b0;
      while (expected_beats.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
